// ----- rtl/heq_pkg.sv -----
// heq_pkg: shared constants, item codes, controller states and the
// command/status structs that join heq_ctrl and heq_datapath.
// No dependencies.
package heq_pkg;

   localparam int GRAY_LEVELS = 256;
   localparam int MAX_PIXELS  = 16777216;

   localparam int LEVEL_W = (GRAY_LEVELS > 2) ? $clog2(GRAY_LEVELS) : 1;
   localparam int COUNT_W = $clog2(MAX_PIXELS + 1);
   localparam int CDF_W   = COUNT_W + LEVEL_W;
   localparam int NUM_W   = CDF_W + 8;
   localparam int OUT_W   = 8;
   localparam int RGB_W   = 24;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_BUILD = 2'd1;
   localparam logic [1:0] CMD_MAP   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD_RD,
      S_LOAD_WR,
      S_MAP_RD,
      S_MAP_WAIT,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_EQ_RD,
      S_EQ_ACC,
      S_EQ_PREP,
      S_EQ_CHK,
      S_EQ_DIV,
      S_EQ_WR
   } state_type;

   typedef struct packed {
      logic take_item;
      logic hist_rd;
      logic addr_idx;
      logic hist_wr;
      logic table_rd;
      logic rsp_load;
      logic idx_clr;
      logic idx_inc;
      logic cdf_clr;
      logic cdfmin_load;
      logic cdf_acc;
      logic eq_prep;
      logic zero_q;
      logic sat_q;
      logic div_start;
      logic div_step;
      logic table_wr;
      logic frame_clr;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic bin_nz;
      logic idx_last;
      logic eq_use;
      logic eq_over;
      logic div_last;
   } status_type;

endpackage

// ----- rtl/histogram_equalize_gray.sv -----
// Histogram equalization of the gray level (R+G+B)/3 of RGB pixels. One item
// is taken at a time. A load item runs accept, histogram read and histogram
// write; a map item runs accept, table read and output load, and the output
// load waits while rsp_stall still holds the output register. A build item
// first scans the histogram for its first nonzero bin, then walks all 256
// levels, sending each entry that needs it through the bit-per-cycle restoring
// divider; the divider and the single histogram port set the build length.
// Depends on heq_pkg, heq_ctrl and heq_datapath.
module histogram_equalize_gray (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [heq_pkg::RGB_W-1:0]     req_pixel_rgb,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [heq_pkg::OUT_W-1:0]     rsp_equalized_level
);

   heq_pkg::cmd_type    cmd;
   heq_pkg::status_type sts;

   heq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .sts       (sts),
      .cmd       (cmd)
   );

   heq_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_pixel_rgb       (req_pixel_rgb),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_equalized_level (rsp_equalized_level),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

// ----- rtl/heq_ctrl.sv -----
// heq_ctrl: sequencer for load, build and map items.
// Depends on heq_pkg; drives heq_datapath through cmd_type.
module heq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  heq_pkg::status_type sts,
   output heq_pkg::cmd_type    cmd
);

   heq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= heq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         heq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               case (req_cmd)
                  heq_pkg::CMD_LOAD: begin
                     state_in = heq_pkg::S_LOAD_RD;
                  end
                  heq_pkg::CMD_BUILD: begin
                     cmd.idx_clr = 1'b1;
                     cmd.cdf_clr = 1'b1;
                     state_in    = heq_pkg::S_SCAN_RD;
                  end
                  heq_pkg::CMD_MAP: begin
                     state_in = heq_pkg::S_MAP_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         heq_pkg::S_LOAD_RD: begin
            cmd.hist_rd = 1'b1;
            state_in    = heq_pkg::S_LOAD_WR;
         end
         heq_pkg::S_LOAD_WR: begin
            cmd.hist_wr = 1'b1;
            state_in    = heq_pkg::S_IDLE;
         end
         heq_pkg::S_MAP_RD: begin
            cmd.table_rd = 1'b1;
            state_in     = heq_pkg::S_MAP_WAIT;
         end
         heq_pkg::S_MAP_WAIT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = heq_pkg::S_IDLE;
            end
         end
         heq_pkg::S_SCAN_RD: begin
            cmd.hist_rd  = 1'b1;
            cmd.addr_idx = 1'b1;
            state_in     = heq_pkg::S_SCAN_CHK;
         end
         heq_pkg::S_SCAN_CHK: begin
            if (sts.bin_nz) begin
               cmd.cdfmin_load = 1'b1;
               cmd.idx_clr     = 1'b1;
               state_in        = heq_pkg::S_EQ_RD;
            end else if (sts.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = heq_pkg::S_EQ_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = heq_pkg::S_SCAN_RD;
            end
         end
         heq_pkg::S_EQ_RD: begin
            cmd.hist_rd  = 1'b1;
            cmd.addr_idx = 1'b1;
            state_in     = heq_pkg::S_EQ_ACC;
         end
         heq_pkg::S_EQ_ACC: begin
            cmd.cdf_acc = 1'b1;
            state_in    = heq_pkg::S_EQ_PREP;
         end
         heq_pkg::S_EQ_PREP: begin
            cmd.eq_prep = 1'b1;
            state_in    = heq_pkg::S_EQ_CHK;
         end
         heq_pkg::S_EQ_CHK: begin
            if (!sts.eq_use) begin
               cmd.zero_q = 1'b1;
               state_in   = heq_pkg::S_EQ_WR;
            end else if (sts.eq_over) begin
               cmd.sat_q = 1'b1;
               state_in  = heq_pkg::S_EQ_WR;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = heq_pkg::S_EQ_DIV;
            end
         end
         heq_pkg::S_EQ_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = heq_pkg::S_EQ_WR;
            end
         end
         heq_pkg::S_EQ_WR: begin
            cmd.table_wr = 1'b1;
            if (sts.idx_last) begin
               cmd.frame_clr = 1'b1;
               state_in      = heq_pkg::S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = heq_pkg::S_EQ_RD;
            end
         end
         default: begin
            state_in = heq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/heq_datapath.sv -----
// heq_datapath: gray level, histogram and level table memories, cdf
// accumulator, restoring divider and the output register.
// Depends on heq_pkg; commanded by heq_ctrl.
module heq_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [heq_pkg::RGB_W-1:0]      req_pixel_rgb,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [heq_pkg::OUT_W-1:0]      rsp_equalized_level,
   input  heq_pkg::cmd_type               cmd,
   output heq_pkg::status_type            sts
);

   localparam int LW = heq_pkg::LEVEL_W;
   localparam int CW = heq_pkg::COUNT_W;
   localparam int DW = heq_pkg::CDF_W;
   localparam int NW = heq_pkg::NUM_W;
   localparam int OW = heq_pkg::OUT_W;
   localparam int DEN_SH_W = CW + 7;

   logic [CW-1:0] hist_mem [heq_pkg::GRAY_LEVELS];
   logic [OW-1:0] table_mem [heq_pkg::GRAY_LEVELS];
   logic [heq_pkg::GRAY_LEVELS-1:0] hist_vld_ff;

   logic [LW-1:0]       gray_ff, idx_ff, hist_addr;
   logic [CW-1:0]       hist_rd_ff, bin, bin_inc;
   logic                hist_vld_rd_ff;
   logic [OW-1:0]       tbl_rd_ff;
   logic                built_ff;
   logic [CW-1:0]       pixels_ff, pixels_in;
   logic [CW-1:0]       cdfmin_ff, den_ff;
   logic [DW-1:0]       cdf_ff, diff;
   logic [NW-1:0]       num_ff, rem_ff;
   logic                use_ff;
   logic [DEN_SH_W-1:0] den_sh_ff;
   logic [2:0]          step_ff;
   logic [OW-1:0]       q_ff;
   logic                trial_ok;
   logic                rsp_valid_ff;
   logic [OW-1:0]       rsp_level_ff;

   logic [9:0]  rgb_sum;
   logic [19:0] rgb_prod;
   logic [7:0]  gray8;
   logic [LW-1:0] gray_in;

   // sum / 3 as (sum * 683) >> 11, exact for sums up to 765
   assign rgb_sum  = 10'(req_pixel_rgb[23:16]) + 10'(req_pixel_rgb[15:8])
                   + 10'(req_pixel_rgb[7:0]);
   assign rgb_prod = 20'(rgb_sum) * 20'd683;
   assign gray8    = rgb_prod[18:11];
   assign gray_in  = (32'(gray8) > heq_pkg::GRAY_LEVELS - 1) ?
                     LW'(heq_pkg::GRAY_LEVELS - 1) : LW'(gray8);

   assign hist_addr = cmd.addr_idx ? idx_ff : gray_ff;
   assign bin       = hist_vld_rd_ff ? hist_rd_ff : '0;
   assign bin_inc   = (32'(bin) < heq_pkg::MAX_PIXELS) ? bin + CW'(1)
                                                       : CW'(heq_pkg::MAX_PIXELS);
   assign pixels_in = (32'(pixels_ff) < heq_pkg::MAX_PIXELS) ? pixels_ff + CW'(1)
                                                             : CW'(heq_pkg::MAX_PIXELS);
   assign diff      = cdf_ff - DW'(cdfmin_ff);
   assign trial_ok  = rem_ff >= NW'(den_sh_ff);

   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign sts.bin_nz   = bin != '0;
   assign sts.idx_last = idx_ff == LW'(heq_pkg::GRAY_LEVELS - 1);
   assign sts.eq_use   = use_ff;
   assign sts.eq_over  = num_ff >= NW'({den_ff, 8'd0});
   assign sts.div_last = step_ff == 3'd0;

   always_ff @(posedge clock) begin
      if (cmd.hist_rd) begin
         hist_rd_ff     <= hist_mem[hist_addr];
         hist_vld_rd_ff <= hist_vld_ff[hist_addr];
      end
      if (cmd.hist_wr) begin
         hist_mem[gray_ff] <= bin_inc;
      end
      if (cmd.table_rd) begin
         tbl_rd_ff <= table_mem[gray_ff];
      end
      if (cmd.table_wr) begin
         table_mem[idx_ff] <= q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         gray_ff <= gray_in;
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + LW'(1);
      end
      if (cmd.cdf_clr) begin
         cdf_ff    <= '0;
         cdfmin_ff <= '0;
      end else begin
         if (cmd.cdfmin_load) begin
            cdfmin_ff <= bin;
         end
         if (cmd.cdf_acc) begin
            cdf_ff <= cdf_ff + DW'(bin);
         end
      end
      if (cmd.eq_prep) begin
         use_ff <= (pixels_ff > cdfmin_ff) && (cdf_ff >= DW'(cdfmin_ff));
         num_ff <= NW'({diff, 8'd0}) - NW'(diff);
         den_ff <= pixels_ff - cdfmin_ff;
      end
      if (cmd.zero_q) begin
         q_ff <= '0;
      end else if (cmd.sat_q) begin
         q_ff <= '1;
      end else if (cmd.div_start) begin
         q_ff      <= '0;
         rem_ff    <= num_ff;
         den_sh_ff <= {den_ff, 7'd0};
         step_ff   <= 3'd7;
      end else if (cmd.div_step) begin
         q_ff      <= {q_ff[OW-2:0], trial_ok};
         rem_ff    <= trial_ok ? rem_ff - NW'(den_sh_ff) : rem_ff;
         den_sh_ff <= den_sh_ff >> 1;
         step_ff   <= step_ff - 3'd1;
      end
      if (cmd.rsp_load) begin
         rsp_level_ff <= built_ff ? tbl_rd_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff  <= '0;
         pixels_ff    <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.frame_clr) begin
            hist_vld_ff <= '0;
            pixels_ff   <= '0;
            built_ff    <= 1'b1;
         end else if (cmd.hist_wr) begin
            hist_vld_ff[gray_ff] <= 1'b1;
            pixels_ff            <= pixels_in;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_equalized_level = rsp_level_ff;

   a_pixels_sat: assert property (@(posedge clock) disable iff (reset)
      32'(pixels_ff) <= heq_pkg::MAX_PIXELS)
      else $error("pixel count beyond saturation");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < NW'({den_sh_ff, 1'b0}))
      else $error("divider remainder out of range");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten");

   a_frame_clr: assert property (@(posedge clock) disable iff (reset)
      cmd.frame_clr |=> (pixels_ff == '0) && (hist_vld_ff == '0))
      else $error("frame not cleared after build");

endmodule
